@@ rtl/adsr_envelope_level_unit_macros.svh @@
// Assertion macros shared by the ADSR envelope level unit RTL.
`ifndef ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ADSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adsr assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ADSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adsr assertion failed");
`else
`define ADSR_ASSERT_IMP(label, ante, cons)
`define ADSR_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/adsr_pkg.sv @@
// Types and constants for the ADSR envelope level unit.
`default_nettype none
package adsr_pkg;
  localparam int TIME_BITS  = 24;
  localparam int LVL_W      = 17;
  localparam int Q_W        = 17;
  localparam int DIVD_W     = TIME_BITS + Q_W;
  localparam int CFG_IDX_W  = 2;
  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] elapsed_ticks;
    logic                 key_released;
    logic [TIME_BITS-1:0] release_tick;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             done_res;
  } out_item_t;

  // Divider cell payload: partial remainder, dividend/quotient shift word, divisor.
  typedef struct packed {
    logic [TIME_BITS-1:0] rem;
    logic [Q_W-1:0]       work;
    logic [TIME_BITS-1:0] dvs;
  } div_t;

  // Item context carried alongside the divider.
  typedef struct packed {
    logic                 done;
    logic                 rel;
    logic                 hold;
    logic [TIME_BITS-1:0] rdiff;
    logic [LVL_W-1:0]     base;
    logic [LVL_W-1:0]     held;
  } side_t;
endpackage
`default_nettype wire

@@ rtl/adsr_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per item.
`default_nettype none
module adsr_div_cell
  import adsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  valid_i,
  input  wire div_t  div_i,
  input  wire side_t side_i,
  output logic       valid_o,
  output div_t       div_o,
  output side_t      side_o
);
  logic              valid_r;
  div_t              div_r, div_nxt;
  side_t             side_r;
  logic [TIME_BITS:0] trial;
  logic [TIME_BITS:0] diff;
  logic              ge;

  always_comb begin
    trial = {div_i.rem, div_i.work[Q_W-1]};
    diff  = trial - {1'b0, div_i.dvs};
    ge    = trial >= {1'b0, div_i.dvs};
    div_nxt.rem  = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    div_nxt.work = {div_i.work[Q_W-2:0], ge};
    div_nxt.dvs  = div_i.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign div_o   = div_r;
  assign side_o  = side_r;
endmodule
`default_nettype wire

@@ rtl/adsr_div_chain.sv @@
// Row of division cells, one quotient bit per cell, one item per cycle.
`default_nettype none
module adsr_div_chain
  import adsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  valid_i,
  input  wire div_t  div_i,
  input  wire side_t side_i,
  output logic       valid_o,
  output logic [Q_W-1:0] quot_o,
  output side_t      side_o
);
  logic  vld [Q_W+1];
  div_t  dv  [Q_W+1];
  side_t sd  [Q_W+1];

  assign vld[0] = valid_i;
  assign dv[0]  = div_i;
  assign sd[0]  = side_i;

  for (genvar g = 0; g < Q_W; g++) begin : g_cell
    adsr_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[g]),
      .div_i   (dv[g]),
      .side_i  (sd[g]),
      .valid_o (vld[g+1]),
      .div_o   (dv[g+1]),
      .side_o  (sd[g+1])
    );
  end

  assign valid_o = vld[Q_W];
  assign quot_o  = dv[Q_W].work;
  assign side_o  = sd[Q_W];
endmodule
`default_nettype wire

@@ rtl/adsr_envelope_level_unit.sv @@
// Top level of the linear ADSR envelope level unit.
//
// Usage
//   Input: raise start with in_data (elapsed ticks, released flag, release
//   tick); the item is transferred at the edge where start is high and busy
//   is low. busy stays low, so one item may be transferred every cycle.
//   Output: out_valid is high for exactly one cycle with out_data (level in
//   unsigned Q1.16 and done flag). The receiver cannot stall the unit; each
//   result must be taken in the cycle it is shown.
//   Config: cfg_we/cfg_idx/cfg_wdata write attack, decay, sustain and release
//   registers; write only while no item is in flight.
// Timing
//   Throughput is one item per cycle. The pipeline is two chained 17-cell
//   restoring dividers (one quotient bit per cell), the first giving the held
//   level, the second the release ramp, plus five registered set-up stages
//   and the output register.
// Reset
//   rst_n (synchronous, active low) empties the pipeline and restores the
//   registers: attack, decay, release 0 and sustain at full scale.
`default_nettype none
`include "adsr_envelope_level_unit_macros.svh"
module adsr_envelope_level_unit
  import adsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [TIME_BITS-1:0] cfg_wdata
);
  // config registers
  logic [TIME_BITS-1:0] attack_r, decay_r, release_r;
  logic [LVL_W-1:0]     sustain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      sustain_r <= FULL_SCALE;
      release_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ATTACK:  attack_r  <= cfg_wdata;
        REG_DECAY:   decay_r   <= cfg_wdata;
        REG_SUSTAIN: sustain_r <= cfg_wdata[LVL_W-1:0];
        REG_RELEASE: release_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                 accept;
  logic [LVL_W-1:0]     s_sat;
  logic [LVL_W-1:0]     span;
  logic [TIME_BITS:0]   sum_ad;
  assign accept = start && !busy;
  assign s_sat  = (sustain_r > FULL_SCALE) ? FULL_SCALE : sustain_r;
  assign span   = FULL_SCALE - s_sat;
  assign sum_ad = {1'b0, attack_r} + {1'b0, decay_r};

  // Stage 1: release phase decision, pick the time at which the held
  // envelope is evaluated (release tick once the ramp has started).
  logic                 p1_valid_r;
  logic [TIME_BITS-1:0] p1_x_r, p1_x_nxt, p1_rdiff_r, p1_rdiff_nxt;
  logic                 p1_done_r, p1_done_nxt, p1_rel_r, p1_rel_nxt;
  logic [TIME_BITS:0]   sum_rr;

  always_comb begin
    sum_rr       = {1'b0, in_data.release_tick} + {1'b0, release_r};
    p1_done_nxt  = in_data.key_released && ({1'b0, in_data.elapsed_ticks} > sum_rr);
    p1_rel_nxt   = in_data.key_released && !p1_done_nxt &&
                   (in_data.elapsed_ticks > in_data.release_tick);
    p1_x_nxt     = p1_rel_nxt ? in_data.release_tick : in_data.elapsed_ticks;
    p1_rdiff_nxt = TIME_BITS'(sum_rr - {1'b0, in_data.elapsed_ticks});
  end

  // Stage 2: which held phase (attack, decay or sustain).
  logic                 p2_valid_r;
  logic                 p2_done_r, p2_rel_r, p2_att_r, p2_hold_r;
  logic                 p2_att_nxt, p2_hold_nxt;
  logic [TIME_BITS-1:0] p2_rdiff_r, p2_x_r, p2_ddiff_r, p2_ddiff_nxt;

  always_comb begin
    p2_att_nxt   = p1_x_r < attack_r;
    p2_hold_nxt  = !p2_att_nxt && !({1'b0, p1_x_r} < sum_ad);
    p2_ddiff_nxt = TIME_BITS'(sum_ad - {1'b0, p1_x_r});
  end

  // Stage 3: dividend and divisor for the held level.
  logic                 p3_valid_r;
  div_t                 p3_div_r, p3_div_nxt;
  side_t                p3_side_r, p3_side_nxt;
  logic [DIVD_W-1:0]    dvd1;

  always_comb begin
    if (p2_att_r) begin
      dvd1 = DIVD_W'({p2_x_r, 16'b0});
    end else begin
      dvd1 = DIVD_W'(p2_ddiff_r) * DIVD_W'(span);
    end
    p3_div_nxt.rem    = dvd1[DIVD_W-1:Q_W];
    p3_div_nxt.work   = dvd1[Q_W-1:0];
    p3_div_nxt.dvs    = p2_att_r ? attack_r : decay_r;
    p3_side_nxt.done  = p2_done_r;
    p3_side_nxt.rel   = p2_rel_r;
    p3_side_nxt.hold  = p2_hold_r;
    p3_side_nxt.rdiff = p2_rdiff_r;
    p3_side_nxt.base  = p2_att_r ? '0 : s_sat;
    p3_side_nxt.held  = '0;
  end

  logic             c1_valid;
  logic [Q_W-1:0]   c1_quot;
  side_t            c1_side;

  adsr_div_chain u_div_held (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p3_valid_r),
    .div_i   (p3_div_r),
    .side_i  (p3_side_r),
    .valid_o (c1_valid),
    .quot_o  (c1_quot),
    .side_o  (c1_side)
  );

  // Stage 4: held level.
  logic             p4_valid_r;
  side_t            p4_side_r, p4_side_nxt;

  always_comb begin
    p4_side_nxt      = c1_side;
    p4_side_nxt.held = c1_side.hold ? s_sat : c1_side.base + c1_quot;
  end

  // Stage 5: release ramp dividend.
  logic              p5_valid_r;
  div_t              p5_div_r, p5_div_nxt;
  side_t             p5_side_r;
  logic [DIVD_W-1:0] dvd2;

  always_comb begin
    dvd2            = DIVD_W'(p4_side_r.rdiff) * DIVD_W'(p4_side_r.held);
    p5_div_nxt.rem  = dvd2[DIVD_W-1:Q_W];
    p5_div_nxt.work = dvd2[Q_W-1:0];
    p5_div_nxt.dvs  = release_r;
  end

  logic             c2_valid;
  logic [Q_W-1:0]   c2_quot;
  side_t            c2_side;

  adsr_div_chain u_div_rel (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p5_valid_r),
    .div_i   (p5_div_r),
    .side_i  (p5_side_r),
    .valid_o (c2_valid),
    .quot_o  (c2_quot),
    .side_o  (c2_side)
  );

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.done_res = c2_side.done;
    if (c2_side.done) begin
      out_data_nxt.level = '0;
    end else if (c2_side.rel) begin
      out_data_nxt.level = c2_quot;
    end else begin
      out_data_nxt.level = c2_side.held;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      p4_valid_r  <= 1'b0;
      p5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= accept;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      p4_valid_r  <= c1_valid;
      p5_valid_r  <= p4_valid_r;
      out_valid_r <= c2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    p1_x_r     <= p1_x_nxt;
    p1_rdiff_r <= p1_rdiff_nxt;
    p1_done_r  <= p1_done_nxt;
    p1_rel_r   <= p1_rel_nxt;
    p2_done_r  <= p1_done_r;
    p2_rel_r   <= p1_rel_r;
    p2_att_r   <= p2_att_nxt;
    p2_hold_r  <= p2_hold_nxt;
    p2_rdiff_r <= p1_rdiff_r;
    p2_x_r     <= p1_x_r;
    p2_ddiff_r <= p2_ddiff_nxt;
    p3_div_r   <= p3_div_nxt;
    p3_side_r  <= p3_side_nxt;
    p4_side_r  <= p4_side_nxt;
    p5_div_r   <= p5_div_nxt;
    p5_side_r  <= p4_side_r;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ADSR_ASSERT_IMP(a_done_zero, out_valid && out_data.done_res, out_data.level == '0)
  `ADSR_ASSERT_IMP(a_level_range, out_valid, out_data.level <= FULL_SCALE)
  `ADSR_ASSERT_IMP(a_done_not_rel, p1_valid_r && p1_done_r, !p1_rel_r)
  `ADSR_ASSERT_IMP(a_held_range, p5_valid_r, p5_side_r.held <= FULL_SCALE)
  `ADSR_ASSERT_NXT(a_accept_flow, accept, p1_valid_r)
endmodule
`default_nettype wire
